// ===== rtl/ps2_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 decoder package
// Scan codes, held-key bit positions and the set-2 character ROMs.
// ----------------------------------------------------------------------------
package ps2_pkg;

  // Codes below this bound count as normal make codes (0 .. 127)
  localparam int TABLE_ENTRIES = 128;
  localparam int ROM_ENTRIES   = 128;
  localparam int ROM_AW        = $clog2(ROM_ENTRIES);

  localparam int SCAN_W = 8;
  localparam int CHAR_W = 8;
  localparam int HELD_W = 5;

  // Stream payload: char_valid, character, held_keys, padded to bytes
  localparam int OUT_BITS = 1 + CHAR_W + HELD_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Scan codes
  localparam logic [SCAN_W-1:0] SC_EXTEND   = 8'hE0;
  localparam logic [SCAN_W-1:0] SC_BREAK    = 8'hF0;
  localparam logic [SCAN_W-1:0] SC_LSHIFT   = 8'h12;
  localparam logic [SCAN_W-1:0] SC_RSHIFT   = 8'h59;
  localparam logic [SCAN_W-1:0] SC_SPACE    = 8'h29;
  localparam logic [SCAN_W-1:0] SC_LEFT     = 8'h6B;
  localparam logic [SCAN_W-1:0] SC_DOWN     = 8'h72;
  localparam logic [SCAN_W-1:0] SC_RIGHT    = 8'h74;
  localparam logic [SCAN_W-1:0] SC_UP       = 8'h75;
  localparam logic [SCAN_W-1:0] SC_KP_SLASH = 8'h4A;
  localparam logic [SCAN_W-1:0] SC_KP_ENTER = 8'h5A;

  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

  // Held-key bit positions
  localparam int HK_UP    = 0;
  localparam int HK_DOWN  = 1;
  localparam int HK_LEFT  = 2;
  localparam int HK_RIGHT = 3;
  localparam int HK_SPACE = 4;

  // Function and control key codes
  localparam logic [7:0] K_F1   = 8'hF1;
  localparam logic [7:0] K_F2   = 8'hF2;
  localparam logic [7:0] K_F3   = 8'hF3;
  localparam logic [7:0] K_F4   = 8'hF4;
  localparam logic [7:0] K_F5   = 8'hF5;
  localparam logic [7:0] K_F6   = 8'hF6;
  localparam logic [7:0] K_F8   = 8'hF8;
  localparam logic [7:0] K_F9   = 8'hF9;
  localparam logic [7:0] K_F10  = 8'hFA;
  localparam logic [7:0] K_F11  = 8'hFB;
  localparam logic [7:0] K_F12  = 8'hFC;
  localparam logic [7:0] K_ALT  = 8'hFD;
  localparam logic [7:0] K_CTL  = 8'hFE;
  localparam logic [7:0] K_CAPS = 8'hFF;
  localparam logic [7:0] K_ESC  = 8'h1B;

  localparam logic [CHAR_W-1:0] ROM_LOWER [ROM_ENTRIES] = '{
    8'h00, K_F9, 8'h00, K_F5, K_F3, K_F1, K_F2, K_F12,
    8'h00, K_F10, K_F8, K_F6, K_F4, 8'h09, 8'h60, 8'h00,
    8'h00, K_ALT, 8'h00, 8'h00, K_CTL, 8'h61, 8'h26, 8'h00,
    8'h00, 8'h00, 8'h77, 8'h73, 8'h71, 8'h7A, 8'h82, 8'h00,
    8'h00, 8'h63, 8'h78, 8'h64, 8'h65, 8'h27, 8'h22, 8'h00,
    8'h00, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h28, 8'h00,
    8'h00, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h79, 8'h2D, 8'h00,
    8'h00, 8'h00, 8'h2C, 8'h6A, 8'h75, 8'h8A, 8'h5F, 8'h00,
    8'h00, 8'h3B, 8'h6B, 8'h69, 8'h6F, 8'h85, 8'h5D, 8'h00,
    8'h00, 8'h3A, 8'h21, 8'h6C, 8'h6D, 8'h70, 8'h29, 8'h00,
    8'h00, 8'h00, 8'h97, 8'h00, 8'h5E, 8'h3D, 8'h00, 8'h00,
    K_CAPS, 8'h00, 8'h0A, 8'h24, 8'h00, 8'h2A, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
    8'h00, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
    8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, K_ESC, 8'h00,
    K_F11, 8'h2B, 8'h33, 8'h2D, 8'h2A, 8'h39, 8'h00, 8'h00
  };

  localparam logic [CHAR_W-1:0] ROM_UPPER [ROM_ENTRIES] = '{
    8'h00, K_F9, 8'h00, K_F5, K_F3, K_F1, K_F2, K_F12,
    8'h00, K_F10, K_F8, K_F6, K_F4, 8'h09, 8'h60, 8'h00,
    8'h00, K_ALT, 8'h00, 8'h00, K_CTL, 8'h41, 8'h31, 8'h00,
    8'h00, 8'h00, 8'h57, 8'h53, 8'h51, 8'h5A, 8'h32, 8'h00,
    8'h00, 8'h43, 8'h58, 8'h44, 8'h45, 8'h34, 8'h33, 8'h00,
    8'h00, 8'h20, 8'h56, 8'h46, 8'h54, 8'h52, 8'h35, 8'h00,
    8'h00, 8'h4E, 8'h42, 8'h48, 8'h47, 8'h59, 8'h36, 8'h00,
    8'h00, 8'h00, 8'h3F, 8'h4A, 8'h55, 8'h37, 8'h38, 8'h00,
    8'h00, 8'h2E, 8'h4B, 8'h49, 8'h4F, 8'h30, 8'h39, 8'h00,
    8'h00, 8'h2F, 8'h15, 8'h4C, 8'h4D, 8'h50, 8'hA7, 8'h00,
    8'h00, 8'h00, 8'h25, 8'h00, 8'h00, 8'h2B, 8'h00, 8'h00,
    K_CAPS, 8'h00, 8'h0A, 8'h9C, 8'h00, 8'hE6, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
    8'h00, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
    8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, K_ESC, 8'h00,
    K_F11, 8'h2B, 8'h33, 8'h2D, 8'h2A, 8'h39, 8'h00, 8'h00
  };

  // Held-key bit for an extended arrow code, zero for anything else
  function automatic logic [HELD_W-1:0] arrow_bit(input logic [SCAN_W-1:0] code);
    logic [HELD_W-1:0] m;
    m = '0;
    case (code)
      SC_LEFT:  m[HK_LEFT]  = 1'b1;
      SC_DOWN:  m[HK_DOWN]  = 1'b1;
      SC_RIGHT: m[HK_RIGHT] = 1'b1;
      SC_UP:    m[HK_UP]    = 1'b1;
      default:  m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/ps2_scan_code_decoder_core.sv =====
// ----------------------------------------------------------------------------
// PS/2 scan code decoder core
// Set-2 scan byte stream in, translated character and held-key mask out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one scan byte per request (prefixes E0/F0 included).
//   m_axis returns exactly one result request per scan byte:
//     char_valid, character (zero unless char_valid) and held_keys, the
//     arrow/space mask after the byte has been applied.
//   The byte is decoded in the accept cycle and the result register loads
//   on that edge. Throughput is one byte per cycle while results are taken;
//   the limit is the single decode stage feeding the result register.
//   When the receiver stalls, the result register holds its request and
//   s_axis_tready drops only while that register is full and not being
//   taken, so a byte can be accepted in the same cycle the previous result
//   leaves.
//   rst (synchronous, active high) clears both prefix flags, both shift
//   flags, the held-key mask and the result valid.
//   Shift state selects the uppercase ROM; caps lock is a plain key code.
// ----------------------------------------------------------------------------
module ps2_scan_code_decoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ps2_pkg::SCAN_W-1:0] s_axis_tdata,   // [7:0] scan_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ps2_pkg::OUT_W-1:0]  m_axis_tdata    // [0] char_valid,
                                                     // [8:1] character,
                                                     // [13:9] held_keys,
                                                     // [15:14] zero
);
  import ps2_pkg::*;

  // Decoder state
  logic              release_pending, release_pending_next;
  logic              extended_pending, extended_pending_next;
  logic              left_shift_down, left_shift_down_next;
  logic              right_shift_down, right_shift_down_next;
  logic [HELD_W-1:0] held_mask, held_mask_next;

  // Result register
  logic              out_valid;
  logic              out_char_valid, char_valid_next;
  logic [CHAR_W-1:0] out_character, character_next;

  logic              accept;
  logic [SCAN_W-1:0] b;
  logic [ROM_AW-1:0] rom_idx;
  logic              in_rom;
  logic              in_table;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign rom_idx       = b[ROM_AW-1:0];
  assign in_rom        = {1'b0, b} < 9'(ROM_ENTRIES);
  // codes between ROM size and table bound give an empty character
  assign in_table      = {1'b0, b} < 9'(TABLE_ENTRIES);

  always_comb begin
    release_pending_next  = release_pending;
    extended_pending_next = extended_pending;
    left_shift_down_next  = left_shift_down;
    right_shift_down_next = right_shift_down;
    held_mask_next        = held_mask;
    char_valid_next       = 1'b0;
    character_next        = '0;

    if (b == SC_EXTEND) begin
      extended_pending_next = 1'b1;
    end else if (b == SC_BREAK) begin
      release_pending_next = 1'b1;
    end else if (release_pending) begin
      // break code: release the shift, space or arrow key it names, then clear both prefixes
      if (extended_pending) begin
        held_mask_next = held_mask & ~arrow_bit(b);
      end else if (b == SC_LSHIFT) begin
        left_shift_down_next = 1'b0;
      end else if (b == SC_SPACE) begin
        held_mask_next[HK_SPACE] = 1'b0;
      end else if (b == SC_RSHIFT) begin
        right_shift_down_next = 1'b0;
      end
      release_pending_next  = 1'b0;
      extended_pending_next = 1'b0;
    end else if (extended_pending) begin
      extended_pending_next = 1'b0;
      if (b == SC_KP_SLASH) begin
        char_valid_next = 1'b1;
        character_next  = CH_SLASH;
      end else if (b == SC_KP_ENTER) begin
        char_valid_next = 1'b1;
        character_next  = CH_NEWLINE;
      end else begin
        held_mask_next = held_mask | arrow_bit(b);
      end
    end else if (in_table) begin
      if (b == SC_LSHIFT) begin
        left_shift_down_next = 1'b1;
      end else if (b == SC_RSHIFT) begin
        right_shift_down_next = 1'b1;
      end else begin
        char_valid_next = 1'b1;
        if (in_rom) begin
          character_next = (left_shift_down || right_shift_down) ?
                           ROM_UPPER[rom_idx] : ROM_LOWER[rom_idx];
        end
      end
      if (b == SC_SPACE) begin
        held_mask_next[HK_SPACE] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      release_pending  <= 1'b0;
      extended_pending <= 1'b0;
      left_shift_down  <= 1'b0;
      right_shift_down <= 1'b0;
      held_mask        <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        release_pending  <= release_pending_next;
        extended_pending <= extended_pending_next;
        left_shift_down  <= left_shift_down_next;
        right_shift_down <= right_shift_down_next;
        held_mask        <= held_mask_next;
        out_valid        <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_char_valid <= char_valid_next;
      out_character  <= character_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  // held_mask register already reflects the last accepted byte
  assign m_axis_tdata  = {(OUT_W - OUT_BITS)'(0), held_mask, out_character, out_char_valid};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_char_valid) |-> (out_character == '0))
    else $error("character nonzero without char_valid");

  a_prefix_no_char: assert property (@(posedge clk) disable iff (rst)
    (accept && (b == SC_EXTEND || b == SC_BREAK)) |=> !out_char_valid)
    else $error("prefix byte produced a character");

  a_mask_stable: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(held_mask))
    else $error("held mask changed without a scan byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
